// ===== design/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hash engine.
`default_nettype none

package sha_pkg;

  // Command codes carried in the request cmd field.
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Eight 32-bit words, index 0 is the most significant digest word.
  typedef logic [0:7][31:0] words8_t;

  localparam words8_t HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  function automatic logic [31:0] big_sig0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/sha_in_if.sv =====
// Request channel of the SHA-256 hash engine: command and message byte.
`default_nettype none

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] msg_byte;

  modport source (output valid, output cmd, output msg_byte, input ready);
  modport sink   (input valid, input cmd, input msg_byte, output ready);
endinterface

`default_nettype wire

// ===== design/sha_out_if.sv =====
// Result channel of the SHA-256 hash engine: digest words.
`default_nettype none

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

// ===== design/sha256_hash_engine.sv =====
// SHA-256 hash engine: byte-wide message absorb, padding, compression, digest out.
// Usage: send requests on in_ch. cmd absorb takes msg_byte into the current
// 64-byte block; cmd finish pads the message and returns the digest as eight
// 32-bit words on out_ch, most significant first, last_word high on the eighth.
// Every 64th absorbed byte starts a compression: 64 rounds of the single
// shared round unit, one round a cycle, then a fold of the working words into
// the chaining words. A finish shifts padding and length in at one byte a
// cycle (with an extra block when 56 or more bytes are buffered), then
// compresses each padded block, then sends the eight digest words at one per
// cycle while the receiver is ready.
// in_ch.ready is high only while idle; the block holds one request at a time.
// If the receiver stalls, the current digest word is held on out_ch and
// nothing advances. Once the last word is taken the chaining words return to
// the initial hash values and the byte count to zero.
// Reset (synchronous, rst high) restores the initial hash values, clears the
// byte count and returns to idle; the block buffer needs no clearing pass.
`default_nettype none

module sha256_hash_engine
  import sha_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  state_t       st;
  words8_t      chain;      // chaining words H0..H7
  words8_t      v;          // working words a..h
  logic [511:0] wnd;        // block buffer, then the message schedule window
  logic [63:0]  byte_total; // bytes of the current message
  logic [5:0]   pos;        // bytes shifted into the window since the last block
  logic [5:0]   rnd;        // round counter
  logic [2:0]   idx;        // digest word being sent
  logic         fin;        // finishing: padding blocks under way
  logic         two_blk;    // length must wait for an extra block

  logic         in_acc;
  logic         out_acc;
  logic [63:0]  bit_len;
  logic [2:0]   len_sel;
  logic [7:0]   pad_byte;
  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign in_ch.ready        = (st == ST_IDLE);
  assign out_ch.valid       = (st == ST_EMIT);
  assign out_ch.digest_word = chain[idx];
  assign out_ch.last_word   = (idx == 3'd7);

  // Length field: byte count times eight, big-endian in the last eight bytes.
  assign bit_len  = {byte_total[60:0], 3'b000};
  assign len_sel  = 3'd7 - pos[2:0];
  assign pad_byte = ((pos[5:3] == 3'd7) && !two_blk) ? bit_len[{len_sel, 3'b000} +: 8]
                                                    : 8'h00;

  // Schedule window: word 0 is W[t], word 1 W[t+1], word 9 W[t+9], word 14 W[t+14].
  assign w_cur = wnd[511:480];
  assign w_new = small_sig1(wnd[63:32]) + wnd[223:192] + small_sig0(wnd[479:448]) + w_cur;

  // Shared round unit.
  assign t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w_cur;
  assign t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      chain      <= HASH_INIT;
      byte_total <= '0;
      pos        <= '0;
      rnd        <= '0;
      idx        <= '0;
      fin        <= 1'b0;
      two_blk    <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            pos <= pos + 6'd1;
            v   <= chain;
            if (in_ch.cmd == CMD_ABSORB) begin
              wnd        <= {wnd[503:0], in_ch.msg_byte};
              byte_total <= byte_total + 64'd1;
              if (pos == 6'd63) begin
                st <= ST_ROUND;
              end
            end else begin
              // Append the end marker; decide whether the length needs its own block.
              wnd     <= {wnd[503:0], PAD_MARK};
              fin     <= 1'b1;
              two_blk <= (pos[5:3] == 3'd7);
              st      <= (pos == 6'd63) ? ST_ROUND : ST_PAD;
            end
          end
        end
        ST_PAD: begin
          wnd <= {wnd[503:0], pad_byte};
          pos <= pos + 6'd1;
          v   <= chain;
          if (pos == 6'd63) begin
            st <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          v   <= {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
          wnd <= {wnd[479:0], w_new};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            st <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          if (!fin) begin
            st <= ST_IDLE;
          end else if (two_blk) begin
            two_blk <= 1'b0;
            st      <= ST_PAD;
          end else begin
            st <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              chain      <= HASH_INIT;
              byte_total <= '0;
              fin        <= 1'b0;
              st         <= ST_IDLE;
            end
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // Never take a request while a digest is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while digest pending");

  // Compression starts only with a full window.
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ROUND) |-> (pos == 6'd0))
    else $error("compression on a partial block");

  // The final digest word leaves the engine ready for a new message.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_ch.last_word) |=> (byte_total == 64'd0 && chain == HASH_INIT && !fin))
    else $error("state not restored after digest");

  // A buffered extra block never survives into the digest phase.
  a_no_stale_pad: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!two_blk && fin && pos == 6'd0))
    else $error("digest sent before padding completed");

endmodule

`default_nettype wire

// ===== bench/sha256_hash_engine_test.sv =====
// Testbench for the SHA-256 hash engine: byte requests in, digest words checked against a local model.

module sha256_hash_engine_test
  import sha_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cap on the whole run.
  localparam int LIMIT_CYCLES  = 200000;
  // Quiet time after the last digest word, enough for a finish with the extra
  // padding block to complete.
  localparam int SETTLE_CYCLES = 300;

  // SHA-256 round constants, word 0 first.
  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic clk;
  logic rst;

  sha_in_if  req_ch ();
  sha_out_if dig_ch ();

  sha256_hash_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (dig_ch)
  );

  // Local copy of the hashing state: chaining words, block bytes, length.
  logic [31:0] chain_model [8];
  logic [7:0]  block_model [64];
  logic [63:0] bytes_taken;

  // Digest words still owed by the block, oldest first.
  digest_beat_t digest_beats_due [$];
  digest_beat_t beat_seen;

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Cycles for which the receiver must refuse every digest word.
  int hold_off_left  = 0;

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotr32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_model();
    for (int i = 0; i < 8; i++) chain_model[i] = HASH_INIT[i];
    bytes_taken = '0;
  endfunction

  // Run the 64 rounds over block_model and fold the result into the chain.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {block_model[4*i], block_model[4*i+1], block_model[4*i+2], block_model[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = chain_model[0]; b = chain_model[1]; c = chain_model[2]; d = chain_model[3];
    e = chain_model[4]; f = chain_model[5]; g = chain_model[6]; h = chain_model[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[i] + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_model[0] += a; chain_model[1] += b; chain_model[2] += c; chain_model[3] += d;
    chain_model[4] += e; chain_model[5] += f; chain_model[6] += g; chain_model[7] += h;
  endfunction

  // Apply one accepted request to the model; a finish queues eight digest words.
  function automatic void predict_request(logic cmd, logic [7:0] msg_byte);
    int          fill;
    logic [63:0] bit_len;
    fill = int'(bytes_taken[5:0]);
    if (cmd == CMD_ABSORB) begin
      block_model[fill] = msg_byte;
      bytes_taken++;
      if (bytes_taken[5:0] == 6'd0) compress_block();
    end else begin
      bit_len = bytes_taken << 3;
      block_model[fill] = PAD_MARK;
      fill++;
      // No room left for the length: close this block and start another.
      if (fill > 56) begin
        while (fill < 64) begin
          block_model[fill] = 8'h00;
          fill++;
        end
        compress_block();
        fill = 0;
      end
      while (fill < 56) begin
        block_model[fill] = 8'h00;
        fill++;
      end
      for (int i = 0; i < 8; i++) block_model[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        digest_beats_due.push_back('{word: chain_model[i], last: (i == 7)});
      restart_model();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until taken. Enter in the rising-edge step
  // of the previous handshake (or anywhere before a falling edge); return in
  // the rising-edge step that accepted it, leaving valid high so that a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_request(input logic cmd, input logic [7:0] msg_byte);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= cmd;
    req_ch.msg_byte <= msg_byte;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(cmd, msg_byte);
  endtask

  // Drop valid once no further request follows straight away.
  task automatic hold_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // Wait until every owed digest word has been seen.
  task automatic wait_drained();
    while (digest_beats_due.size() != 0) @(posedge clk);
  endtask

  // One whole message of random bytes, closed by a finish with a random byte
  // that the block must ignore.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_request(CMD_ABSORB, 8'($urandom_range(255, 0)));
    send_request(CMD_FINISH, 8'($urandom_range(255, 0)));
  endtask

  // Mostly short messages, now and then an empty one; the length at which the
  // padding changes shape, 56 bytes, is covered by the directed test.
  function automatic int pick_msg_len();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return 0;
    return $urandom_range(12, 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: refuse everything during a hold-off, otherwise stall at random.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      dig_ch.ready <= 1'b0;
    end else begin
      dig_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Check each accepted digest word against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1) begin
      if (digest_beats_due.size() == 0) begin
        $error("digest_word %08h arrived with none owed", dig_ch.digest_word);
        fail_count++;
      end else begin
        beat_seen = digest_beats_due.pop_front();
        if (dig_ch.digest_word !== beat_seen.word) begin
          $error("digest_word: expected %08h, got %08h", beat_seen.word, dig_ch.digest_word);
          fail_count++;
        end
        if (dig_ch.last_word !== beat_seen.last) begin
          $error("last_word: expected %0b, got %0b", beat_seen.last, dig_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked messages with no idling on either side.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Empty message; the byte carried with the finish is all ones and ignored.
    send_request(CMD_FINISH, 8'hff);
    // "abc", finished with a zero byte.
    send_request(CMD_ABSORB, 8'h61);
    send_request(CMD_ABSORB, 8'h62);
    send_request(CMD_ABSORB, 8'h63);
    send_request(CMD_FINISH, 8'h00);
    // Single extreme bytes.
    send_request(CMD_ABSORB, 8'h00);
    send_request(CMD_FINISH, 8'h5a);
    send_request(CMD_ABSORB, 8'hff);
    send_request(CMD_FINISH, 8'ha5);
    // 56 bytes buffered: the length no longer fits, so padding spills into a
    // second block.
    for (int i = 0; i < 56; i++) send_request(CMD_ABSORB, i[0] ? 8'hff : 8'h00);
    send_request(CMD_FINISH, 8'h80);
    // Pause the sender until every digest word is back.
    hold_requests();
    wait_drained();
  endtask

  // Random messages under one idling profile; stop at a message boundary.
  task automatic test_random(input int idle_pct, input int stall_pct);
    int requests_sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    requests_sent  = 0;
    while (requests_sent < 6) begin
      len = pick_msg_len();
      send_message(len);
      requests_sent += len + 1;
    end
    hold_requests();
    wait_drained();
  endtask

  // Receiver refuses for a long stretch while requests keep coming, so the
  // block stalls mid-digest and refuses the next message's bytes.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    send_message($urandom_range(8, 1));
    send_message($urandom_range(8, 1));
    hold_requests();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  // Watchdog: end the run if it overstays the limit.
  initial begin
    int cycles;
    for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    // Drive every input to a known value from the first instant.
    clk             = 1'b0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = CMD_ABSORB;
    req_ch.msg_byte = 8'h00;
    dig_ch.ready    = 1'b0;
    restart_model();
    for (int i = 0; i < 64; i++) block_model[i] = 8'h00;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(0, 0);
    test_random(61, 0);
    test_random(0, 61);
    test_random(38, 38);
    test_backpressure();

    // Allow late or spurious words to surface before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (digest_beats_due.size() != 0) begin
      $error("%0d digest words never arrived", digest_beats_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sha_pkg.sv
design/sha_in_if.sv
design/sha_out_if.sv
design/sha256_hash_engine.sv
bench/sha256_hash_engine_test.sv
